// ===== src/i2ctbw_pkg.sv =====
// shared types and constants for the three-byte i2c write master
// no dependencies
package i2ctbw_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [BYTE_W-1:0] CTRL_COMMAND  = 8'h00;
  localparam logic [BYTE_W-1:0] CTRL_DATA     = 8'h40;
  localparam logic [BYTE_W-1:0] ADDR_RESET    = 8'h78;
  localparam logic [BYTE_W-1:0] TIMEOUT_RESET = 8'd250;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ADDRESS = 1'b0,
    CFG_TIMEOUT = 1'b1
  } cfg_index_t;

  typedef enum logic [3:0] {
    PH_IDLE        = 4'd0,
    PH_START_SCL   = 4'd1,
    PH_BIT_SETUP   = 4'd2,
    PH_BIT_HIGH    = 4'd3,
    PH_BIT_LOW     = 4'd4,
    PH_ACK_RELEASE = 4'd5,
    PH_ACK_HIGH    = 4'd6,
    PH_ACK_POLL    = 4'd7,
    PH_STOP_LOW    = 4'd8,
    PH_STOP_RISE   = 4'd9,
    PH_STOP_END    = 4'd10,
    PH_STOP_RISE_N = 4'd11,
    PH_STOP_END_N  = 4'd12
  } phase_t;

  typedef enum logic [1:0] {
    BYTE_ADDRESS = 2'd0,
    BYTE_CONTROL = 2'd1,
    BYTE_PAYLOAD = 2'd2
  } byte_sel_t;

  typedef struct packed {
    logic scl;
    logic sda;
    logic busy;
    logic done;
    logic nack;
  } res_t;

endpackage

// ===== src/i2ctbw_core.sv =====
// bus sequencer: frame state and one step per accepted tick word
// depends on i2ctbw_pkg
module i2ctbw_core import i2ctbw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              request,
  input  logic [BYTE_W-1:0] payload,
  input  logic              is_command,
  input  logic              sda_sample,
  input  logic [BYTE_W-1:0] address_byte,
  input  logic [BYTE_W-1:0] timeout,
  output res_t              res
);

  phase_t            phase, phase_next;
  logic [2:0]        bit_counter, bit_counter_next;
  byte_sel_t         byte_index, byte_index_next;
  logic [BYTE_W-1:0] shift_byte, shift_byte_next;
  logic [BYTE_W-1:0] held_payload, held_payload_next;
  logic [BYTE_W-1:0] held_control, held_control_next;
  logic [BYTE_W-1:0] ack_wait_count, ack_wait_count_next;
  logic [BYTE_W:0]   wait_inc;
  logic              scl, sda, done, nack;

  assign wait_inc = {1'b0, ack_wait_count} + {{BYTE_W{1'b0}}, 1'b1};

  always_comb begin
    phase_next          = phase;
    bit_counter_next    = bit_counter;
    byte_index_next     = byte_index;
    shift_byte_next     = shift_byte;
    held_payload_next   = held_payload;
    held_control_next   = held_control;
    ack_wait_count_next = ack_wait_count;
    scl  = 1'b1;
    sda  = 1'b1;
    done = 1'b0;
    nack = 1'b0;
    unique case (phase)
      PH_START_SCL: begin
        scl = 1'b0;
        sda = 1'b0;
        shift_byte_next  = address_byte;
        byte_index_next  = BYTE_ADDRESS;
        bit_counter_next = 3'd0;
        phase_next       = PH_BIT_SETUP;
      end
      PH_BIT_SETUP: begin
        scl = 1'b0;
        sda = shift_byte[BYTE_W-1];
        phase_next = PH_BIT_HIGH;
      end
      PH_BIT_HIGH: begin
        scl = 1'b1;
        sda = shift_byte[BYTE_W-1];
        phase_next = PH_BIT_LOW;
      end
      PH_BIT_LOW: begin
        scl = 1'b0;
        sda = shift_byte[BYTE_W-1];
        shift_byte_next = {shift_byte[BYTE_W-2:0], 1'b0};
        if (bit_counter == 3'd7) begin
          bit_counter_next = 3'd0;
          phase_next       = PH_ACK_RELEASE;
        end else begin
          bit_counter_next = bit_counter + 3'd1;
          phase_next       = PH_BIT_SETUP;
        end
      end
      PH_ACK_RELEASE: begin
        scl = 1'b0;
        phase_next = PH_ACK_HIGH;
      end
      PH_ACK_HIGH: begin
        ack_wait_count_next = '0;
        phase_next          = PH_ACK_POLL;
      end
      PH_ACK_POLL: begin
        if (!sda_sample) begin
          scl = 1'b0;
          unique case (byte_index)
            BYTE_ADDRESS: begin
              byte_index_next = BYTE_CONTROL;
              shift_byte_next = held_control;
              phase_next      = PH_BIT_SETUP;
            end
            BYTE_CONTROL: begin
              byte_index_next = BYTE_PAYLOAD;
              shift_byte_next = held_payload;
              phase_next      = PH_BIT_SETUP;
            end
            default: begin
              phase_next = PH_STOP_LOW;
            end
          endcase
        end else if (wait_inc > {1'b0, timeout}) begin
          scl = 1'b0;
          sda = 1'b0;
          phase_next = PH_STOP_RISE_N;
        end else begin
          ack_wait_count_next = wait_inc[BYTE_W-1:0];
        end
      end
      PH_STOP_LOW: begin
        scl = 1'b0;
        sda = 1'b0;
        phase_next = PH_STOP_RISE;
      end
      PH_STOP_RISE: begin
        sda = 1'b0;
        phase_next = PH_STOP_END;
      end
      PH_STOP_END: begin
        done = 1'b1;
        phase_next = PH_IDLE;
      end
      PH_STOP_RISE_N: begin
        sda = 1'b0;
        phase_next = PH_STOP_END_N;
      end
      PH_STOP_END_N: begin
        done = 1'b1;
        nack = 1'b1;
        phase_next = PH_IDLE;
      end
      default: begin
        phase_next = PH_IDLE;
        if (request) begin
          held_payload_next   = payload;
          held_control_next   = is_command ? CTRL_COMMAND : CTRL_DATA;
          byte_index_next     = BYTE_ADDRESS;
          bit_counter_next    = 3'd0;
          ack_wait_count_next = '0;
          sda = 1'b0;
          phase_next = PH_START_SCL;
        end
      end
    endcase
  end

  always_comb begin
    res.scl  = scl;
    res.sda  = sda;
    res.busy = (phase_next != PH_IDLE);
    res.done = done;
    res.nack = nack;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      bit_counter    <= 3'd0;
      byte_index     <= BYTE_ADDRESS;
      shift_byte     <= '0;
      held_payload   <= '0;
      held_control   <= '0;
      ack_wait_count <= '0;
    end else if (step) begin
      phase          <= phase_next;
      bit_counter    <= bit_counter_next;
      byte_index     <= byte_index_next;
      shift_byte     <= shift_byte_next;
      held_payload   <= held_payload_next;
      held_control   <= held_control_next;
      ack_wait_count <= ack_wait_count_next;
    end
  end

  a_bits_only_when_sending: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_BIT_SETUP || phase == PH_BIT_HIGH || phase == PH_BIT_LOW)
      |-> (byte_index != 2'd3))
    else $error("byte index out of range while sending bits");

  a_done_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (step && done) |=> (phase == PH_IDLE))
    else $error("frame end did not return to idle");

  a_ack_count_cleared: assert property (@(posedge clk) disable iff (rst)
    (step && phase == PH_ACK_HIGH) |=> (ack_wait_count == '0))
    else $error("ack wait count not cleared on the clock rise");

endmodule

// ===== src/i2ctbw_skid.sv =====
// two-entry output stage: result register with a skid register behind it
// depends on i2ctbw_pkg
module i2ctbw_skid import i2ctbw_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic up_valid,
  output logic up_stall,
  input  res_t up_data,
  output logic dn_valid,
  input  logic dn_stall,
  output res_t dn_data
);

  logic main_valid, skid_valid, up_fire;
  res_t main_data, skid_data;

  assign up_stall = skid_valid;
  assign up_fire  = up_valid && !skid_valid;
  assign dn_valid = main_valid;
  assign dn_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || !dn_stall) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= up_fire;
      end
    end else if (up_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid || !dn_stall) begin
      if (skid_valid) begin
        main_data <= skid_data;
      end else if (up_fire) begin
        main_data <= up_data;
      end
    end else if (up_fire) begin
      skid_data <= up_data;
    end
  end

  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid word held with the result register empty");

endmodule

// ===== src/i2c_three_byte_write_master.sv =====
// i2c three-byte write master: one tick word in, one line-drive word out
// output: the result word for a tick is registered in the output stage before it reaches the outputs
// throughput: one tick word per cycle while in_stall is low; a two-word output stage absorbs one stall
// reset: synchronous, active high; idle phase, registers back to 0x78 and 250
// depends on i2ctbw_pkg, i2ctbw_core, i2ctbw_skid
module i2c_three_byte_write_master import i2ctbw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [BYTE_W-1:0]    wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 request,
  input  logic [BYTE_W-1:0]    payload,
  input  logic                 is_command,
  input  logic                 sda_sample,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 scl_level,
  output logic                 sda_level,
  output logic                 busy_res,
  output logic                 done_res,
  output logic                 nack
);

  logic [BYTE_W-1:0] address_byte;
  logic [BYTE_W-1:0] timeout;
  logic              step;
  res_t              step_res, out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      address_byte <= ADDR_RESET;
      timeout      <= TIMEOUT_RESET;
    end else if (wr_en) begin
      unique case (cfg_index_t'(wr_index))
        CFG_ADDRESS: address_byte <= wr_data;
        CFG_TIMEOUT: timeout      <= wr_data;
        default: ;
      endcase
    end
  end

  assign step = in_valid && !in_stall;

  i2ctbw_core u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .request      (request),
    .payload      (payload),
    .is_command   (is_command),
    .sda_sample   (sda_sample),
    .address_byte (address_byte),
    .timeout      (timeout),
    .res          (step_res)
  );

  i2ctbw_skid u_skid (
    .clk      (clk),
    .rst      (rst),
    .up_valid (in_valid),
    .up_stall (in_stall),
    .up_data  (step_res),
    .dn_valid (out_valid),
    .dn_stall (out_stall),
    .dn_data  (out_res)
  );

  assign scl_level = out_res.scl;
  assign sda_level = out_res.sda;
  assign busy_res  = out_res.busy;
  assign done_res  = out_res.done;
  assign nack      = out_res.nack;

  a_nack_with_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && nack) |-> done_res)
    else $error("nack without frame end");

  a_done_ends_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_res) |-> (!busy_res && scl_level && sda_level))
    else $error("frame end without stop and release");

  a_idle_released: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !busy_res) |-> scl_level)
    else $error("clock held low while idle");

endmodule

// ===== sim/i2ctbw_checker.sv =====
`timescale 1ns / 1ps
// line-drive checker for the three-byte i2c write master: follows the tick and result channels,
// keeps its own copy of the bus sequencer and compares every result word in order
// depends on i2ctbw_pkg
module i2ctbw_checker import i2ctbw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [BYTE_W-1:0]    wr_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 request,
  input  logic [BYTE_W-1:0]    payload,
  input  logic                 is_command,
  input  logic                 sda_sample,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 scl_level,
  input  logic                 sda_level,
  input  logic                 busy_res,
  input  logic                 done_res,
  input  logic                 nack,
  output int                   errors,
  output int                   pending,
  output int                   words_checked,
  output int                   frames_ended,
  output int                   frames_nacked
);

  logic [BYTE_W-1:0] addr_reg;
  logic [BYTE_W-1:0] timeout_reg;

  phase_t            ph;
  logic [2:0]        bit_cnt;
  byte_sel_t         byte_sel;
  logic [BYTE_W-1:0] shreg;
  logic [BYTE_W-1:0] held_payload;
  logic [BYTE_W-1:0] held_ctrl;
  logic [BYTE_W-1:0] wait_cnt;
  logic              scl_q;
  logic              sda_q;

  res_t drive_q[$];

  task automatic bus_reset();
    addr_reg     = ADDR_RESET;
    timeout_reg  = TIMEOUT_RESET;
    ph           = PH_IDLE;
    bit_cnt      = '0;
    byte_sel     = BYTE_ADDRESS;
    shreg        = '0;
    held_payload = '0;
    held_ctrl    = '0;
    wait_cnt     = '0;
    scl_q        = 1'b1;
    sda_q        = 1'b1;
  endtask

  task automatic set_lines(input logic s_cl, input logic s_da);
    scl_q = s_cl;
    sda_q = s_da;
  endtask

  task automatic bus_tick(input logic req, input logic [BYTE_W-1:0] pay, input logic cmd,
                          input logic sda_in, output res_t r);
    logic done_v;
    logic nack_v;
    logic [BYTE_W:0] next_wait;
    done_v = 1'b0;
    nack_v = 1'b0;
    case (ph)
      PH_START_SCL: begin
        set_lines(1'b0, 1'b0);
        shreg    = addr_reg;
        byte_sel = BYTE_ADDRESS;
        bit_cnt  = '0;
        ph       = PH_BIT_SETUP;
      end
      PH_BIT_SETUP: begin
        set_lines(1'b0, shreg[7]);
        ph = PH_BIT_HIGH;
      end
      PH_BIT_HIGH: begin
        set_lines(1'b1, shreg[7]);
        ph = PH_BIT_LOW;
      end
      PH_BIT_LOW: begin
        set_lines(1'b0, shreg[7]);
        shreg = shreg << 1;
        if (bit_cnt == 3'd7) begin
          bit_cnt = '0;
          ph      = PH_ACK_RELEASE;
        end else begin
          bit_cnt = bit_cnt + 3'd1;
          ph      = PH_BIT_SETUP;
        end
      end
      PH_ACK_RELEASE: begin
        set_lines(1'b0, 1'b1);
        ph = PH_ACK_HIGH;
      end
      PH_ACK_HIGH: begin
        set_lines(1'b1, 1'b1);
        wait_cnt = '0;
        ph       = PH_ACK_POLL;
      end
      PH_ACK_POLL: begin
        if (!sda_in) begin
          set_lines(1'b0, 1'b1);
          if (byte_sel == BYTE_ADDRESS) begin
            byte_sel = BYTE_CONTROL;
            shreg    = held_ctrl;
            ph       = PH_BIT_SETUP;
          end else if (byte_sel == BYTE_CONTROL) begin
            byte_sel = BYTE_PAYLOAD;
            shreg    = held_payload;
            ph       = PH_BIT_SETUP;
          end else begin
            ph = PH_STOP_LOW;
          end
        end else begin
          next_wait = {1'b0, wait_cnt} + 1'b1;
          if (next_wait > {1'b0, timeout_reg}) begin
            set_lines(1'b0, 1'b0);
            ph = PH_STOP_RISE_N;
          end else begin
            wait_cnt = next_wait[BYTE_W-1:0];
            set_lines(1'b1, 1'b1);
          end
        end
      end
      PH_STOP_LOW: begin
        set_lines(1'b0, 1'b0);
        ph = PH_STOP_RISE;
      end
      PH_STOP_RISE: begin
        set_lines(1'b1, 1'b0);
        ph = PH_STOP_END;
      end
      PH_STOP_END: begin
        set_lines(1'b1, 1'b1);
        done_v = 1'b1;
        ph     = PH_IDLE;
      end
      PH_STOP_RISE_N: begin
        set_lines(1'b1, 1'b0);
        ph = PH_STOP_END_N;
      end
      PH_STOP_END_N: begin
        set_lines(1'b1, 1'b1);
        done_v = 1'b1;
        nack_v = 1'b1;
        ph     = PH_IDLE;
      end
      default: begin
        ph = PH_IDLE;
        set_lines(1'b1, 1'b1);
        if (req) begin
          held_payload = pay;
          held_ctrl    = cmd ? CTRL_COMMAND : CTRL_DATA;
          byte_sel     = BYTE_ADDRESS;
          bit_cnt      = '0;
          wait_cnt     = '0;
          set_lines(1'b1, 1'b0);
          ph           = PH_START_SCL;
        end
      end
    endcase
    r.scl  = scl_q;
    r.sda  = sda_q;
    r.busy = (ph != PH_IDLE);
    r.done = done_v;
    r.nack = nack_v;
  endtask

  task automatic check_field(input string name, input logic exp_v, input logic got_v);
    if (exp_v !== got_v) begin
      errors = errors + 1;
      $display("%0t ns: %s mismatch, expected %b actual %b", $time, name, exp_v, got_v);
    end
  endtask

  initial begin
    errors        = 0;
    pending       = 0;
    words_checked = 0;
    frames_ended  = 0;
    frames_nacked = 0;
    bus_reset();
  end

  always @(posedge clk) begin
    res_t want;
    res_t seen;
    if (rst) begin
      bus_reset();
      drive_q.delete();
    end else begin
      if (wr_en) begin
        if (wr_index == CFG_ADDRESS) addr_reg = wr_data;
        else if (wr_index == CFG_TIMEOUT) timeout_reg = wr_data;
      end
      if (in_valid && !in_stall) begin
        bus_tick(request, payload, is_command, sda_sample, want);
        drive_q.push_back(want);
      end
      if (out_valid && !out_stall) begin
        seen = {scl_level, sda_level, busy_res, done_res, nack};
        if (drive_q.size() == 0) begin
          errors = errors + 1;
          $display("%0t ns: result word with nothing expected, actual %b", $time, seen);
        end else begin
          want = drive_q.pop_front();
          check_field("scl_level", want.scl, seen.scl);
          check_field("sda_level", want.sda, seen.sda);
          check_field("busy_res", want.busy, seen.busy);
          check_field("done_res", want.done, seen.done);
          check_field("nack", want.nack, seen.nack);
          words_checked = words_checked + 1;
          if (want.done) frames_ended = frames_ended + 1;
          if (want.nack) frames_nacked = frames_nacked + 1;
        end
      end
    end
    pending = drive_q.size();
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// top of the i2c write master testbench: clock, reset, register writes, tick stimulus
// and result back-pressure; the verdict comes from the failure count of i2ctbw_checker
// depends on i2ctbw_pkg, i2c_three_byte_write_master, i2ctbw_checker
module tb_top;
  import i2ctbw_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 60;

  typedef enum int {SLAVE_ACKS, SLAVE_SLOW, SLAVE_ABSENT, LINE_NOISE} slave_mode_t;

  logic                 clk;
  logic                 rst;
  logic                 wr_en;
  logic [CFG_IDX_W-1:0] wr_index;
  logic [BYTE_W-1:0]    wr_data;
  logic                 in_valid;
  logic                 in_stall;
  logic                 request;
  logic [BYTE_W-1:0]    payload;
  logic                 is_command;
  logic                 sda_sample;
  logic                 out_valid;
  logic                 out_stall;
  logic                 scl_level;
  logic                 sda_level;
  logic                 busy_res;
  logic                 done_res;
  logic                 nack;

  int errors;
  int pending;
  int words_checked;
  int frames_ended;
  int frames_nacked;
  int quiet_cycles;
  int ticks_sent;
  int send_burst;
  bit send_no_gaps;

  i2c_three_byte_write_master uut (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .request    (request),
    .payload    (payload),
    .is_command (is_command),
    .sda_sample (sda_sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .scl_level  (scl_level),
    .sda_level  (sda_level),
    .busy_res   (busy_res),
    .done_res   (done_res),
    .nack       (nack)
  );

  i2ctbw_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .wr_en         (wr_en),
    .wr_index      (wr_index),
    .wr_data       (wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .request       (request),
    .payload       (payload),
    .is_command    (is_command),
    .sda_sample    (sda_sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .scl_level     (scl_level),
    .sda_level     (sda_level),
    .busy_res      (busy_res),
    .done_res      (done_res),
    .nack          (nack),
    .errors        (errors),
    .pending       (pending),
    .words_checked (words_checked),
    .frames_ended  (frames_ended),
    .frames_nacked (frames_nacked)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  task automatic send_tick(input logic req, input logic [BYTE_W-1:0] pay, input logic cmd,
                           input logic sda_in);
    int gap;
    if (send_burst == 0) begin
      send_no_gaps = ($urandom_range(0, 3) == 0);
      send_burst   = 40;
    end
    send_burst = send_burst - 1;
    gap = send_no_gaps ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    request    <= req;
    payload    <= pay;
    is_command <= cmd;
    sda_sample <= sda_in;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ticks_sent = ticks_sent + 1;
  endtask

  task automatic write_regs(input logic [BYTE_W-1:0] addr, input logic [BYTE_W-1:0] tmo);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= CFG_ADDRESS;
    wr_data  <= addr;
    @(posedge clk);
    wr_index <= CFG_TIMEOUT;
    wr_data  <= tmo;
    @(posedge clk);
    wr_en    <= 1'b0;
  endtask

  task automatic run_slave(input logic [BYTE_W-1:0] addr, input logic [BYTE_W-1:0] tmo,
                           input slave_mode_t mode, input int count);
    logic sda_in;
    logic req;
    write_regs(addr, tmo);
    repeat (count) begin
      case (mode)
        SLAVE_ACKS:   sda_in = ($urandom_range(0, 3) == 0);
        SLAVE_SLOW:   sda_in = ($urandom_range(0, 7) != 0);
        SLAVE_ABSENT: sda_in = 1'b1;
        default:      sda_in = 1'($urandom_range(0, 1));
      endcase
      req = (mode == LINE_NOISE) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 2) == 0);
      send_tick(req, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), sda_in);
    end
  endtask

  // receiver side, with one long hold-off so the output stage fills and the input stalls
  initial begin
    int gap;
    int burst;
    int taken;
    bit no_gaps;
    bit held_off;
    burst    = 0;
    taken    = 0;
    no_gaps  = 1'b0;
    held_off = 1'b0;
    out_stall = 1'b0;
    forever begin
      if (burst == 0) begin
        no_gaps = ($urandom_range(0, 3) == 0);
        burst   = 40;
      end
      burst = burst - 1;
      gap = no_gaps ? 0 : $urandom_range(0, 8);
      if (!held_off && taken >= 100) begin
        held_off = 1'b1;
        gap      = HOLD_OFF_CYCLES;
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken = taken + 1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    rst          = 1'b1;
    wr_en        = 1'b0;
    wr_index     = CFG_ADDRESS;
    wr_data      = '0;
    in_valid     = 1'b0;
    request      = 1'b0;
    payload      = '0;
    is_command   = 1'b0;
    sda_sample   = 1'b1;
    ticks_sent   = 0;
    send_burst   = 0;
    send_no_gaps = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // absent slave with zero timeout: address all ones, nack on the first poll,
    // requests held high throughout so busy and done-tick requests are ignored
    write_regs(8'hFF, 8'd0);
    for (int k = 0; k < 32; k++) begin
      send_tick(1'b1, k[0] ? 8'h00 : 8'hFF, k[1], 1'b1);
    end

    run_slave(ADDR_RESET, TIMEOUT_RESET, SLAVE_ACKS, 250);
    run_slave(8'h00, 8'd0, LINE_NOISE, 150);
    run_slave(8'hFF, 8'd255, SLAVE_ABSENT, 320);
    run_slave(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 15)),
              SLAVE_SLOW, 150);
    run_slave(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
              SLAVE_ACKS, 150);

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d tick words sent and %0d result words checked", ticks_sent, words_checked);
    $display("%0d frames ended with stop, %0d of them on an ack timeout",
             frames_ended, frames_nacked);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
